// ===== hdl/dpdc_pkg.sv =====
// Package: widths, register indexes and reset values for the press duration classifier.
package dpdc_pkg;

	localparam int unsigned TimeW   = 32;
	localparam int unsigned PeriodW = 10;
	localparam int unsigned CountW  = 8;
	localparam int unsigned ThreshW = 16;
	localparam int unsigned IndW    = 16;
	localparam int unsigned CfgDataW = 16;
	localparam int unsigned CfgRegs  = 4;
	localparam int unsigned CfgIdxW  = $clog2(CfgRegs);

	typedef enum logic [CfgIdxW-1:0] {
		CFG_POLL_PERIOD = 2'd0,
		CFG_STABLE_CNT  = 2'd1,
		CFG_LONG_THRESH = 2'd2,
		CFG_INDICATION  = 2'd3
	} cfg_idx_t;

	localparam logic [PeriodW-1:0] PollPeriodRst = 10'd10;
	localparam logic [CountW-1:0]  StableCntRst  = 8'd5;
	localparam logic [ThreshW-1:0] LongThreshRst = 16'd500;
	localparam logic [IndW-1:0]    IndicationRst = 16'd1000;

endpackage

// ===== hdl/debounced_press_duration_classifier.sv =====
// Top level: debounced button press duration classifier with short/long lamps.
// An accepted item goes through the input register, then the result register, to result valid.
// Throughput: one item per cycle unless stalled; state update and result are computed in one pass.
// in_stall rises only while the input register holds an item and the result register is stalled.
// Reset: asynchronous active low; clears valids, lamps and press state, loads register defaults.
module debounced_press_duration_classifier
	import dpdc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                button_level,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                press_event,
	output logic [TimeW-1:0]    press_len_ms,
	output logic                is_long,
	output logic                green_lamp,
	output logic                red_lamp
);

	logic [PeriodW-1:0] poll_period_q;
	logic [CountW-1:0]  stable_count_q;
	logic [ThreshW-1:0] long_thresh_q;
	logic [IndW-1:0]    indication_q;

	logic               valid_s1;
	logic               level_s1;

	logic               prior_level_q;
	logic [CountW-1:0]  stable_cnt_q;
	logic               press_active_q;
	logic [TimeW-1:0]   press_start_q;
	logic [TimeW-1:0]   now_q;
	logic [TimeW-1:0]   lamp_on_q;
	logic               green_q;
	logic               red_q;

	logic               out_valid_q;
	logic               event_q;
	logic [TimeW-1:0]   duration_q;
	logic               is_long_q;

	logic               advance;
	logic               step;
	logic [TimeW-1:0]   now_next;
	logic               changed;
	logic [CountW-1:0]  cnt_next;
	logic               settled;
	logic               start_press;
	logic               end_press;
	logic [TimeW-1:0]   duration_next;
	logic               long_next;
	logic               green_lit;
	logic               red_lit;
	logic [TimeW-1:0]   lamp_diff;
	logic               lamps_off;

	assign advance  = !out_valid_q || !out_stall;
	assign step     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	always_comb begin
		now_next      = now_q + TimeW'(poll_period_q);
		changed       = level_s1 != prior_level_q;
		cnt_next      = stable_cnt_q;
		if (changed) begin
			cnt_next = '0;
		end else if (stable_cnt_q < stable_count_q) begin
			cnt_next = stable_cnt_q + CountW'(1);
		end
		settled       = !changed && (cnt_next == stable_count_q);
		start_press   = settled && level_s1 && !press_active_q;
		end_press     = settled && !level_s1 && press_active_q;
		duration_next = end_press ? (now_next - press_start_q) : '0;
		long_next     = end_press && (duration_next >= TimeW'(long_thresh_q));
		green_lit     = green_q || (end_press && !long_next);
		red_lit       = red_q || (end_press && long_next);
		lamp_diff     = end_press ? '0 : (now_next - lamp_on_q);
		lamps_off     = (green_lit || red_lit) && (lamp_diff >= TimeW'(indication_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_period_q  <= PollPeriodRst;
			stable_count_q <= StableCntRst;
			long_thresh_q  <= LongThreshRst;
			indication_q   <= IndicationRst;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_POLL_PERIOD: poll_period_q  <= cfg_data[PeriodW-1:0];
				CFG_STABLE_CNT:  stable_count_q <= cfg_data[CountW-1:0];
				CFG_LONG_THRESH: long_thresh_q  <= cfg_data[ThreshW-1:0];
				CFG_INDICATION:  indication_q   <= cfg_data[IndW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			level_s1 <= button_level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prior_level_q  <= 1'b0;
			stable_cnt_q   <= '0;
			press_active_q <= 1'b0;
			press_start_q  <= '0;
			now_q          <= '0;
			lamp_on_q      <= '0;
			green_q        <= 1'b0;
			red_q          <= 1'b0;
		end else if (step) begin
			now_q         <= now_next;
			prior_level_q <= level_s1;
			stable_cnt_q  <= cnt_next;
			if (start_press) begin
				press_active_q <= 1'b1;
				press_start_q  <= now_next;
			end else if (end_press) begin
				press_active_q <= 1'b0;
				lamp_on_q      <= now_next;
			end
			green_q <= green_lit && !lamps_off;
			red_q   <= red_lit && !lamps_off;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			event_q    <= end_press;
			duration_q <= duration_next;
			is_long_q  <= long_next;
		end
	end

	assign out_valid    = out_valid_q;
	assign press_event  = event_q;
	assign press_len_ms = duration_q;
	assign is_long      = is_long_q;
	assign green_lamp   = green_q;
	assign red_lamp     = red_q;

	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> !in_stall)
		else $error("input stalled while result register empty");

	a_idle_result_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !event_q) |-> (duration_q == '0 && !is_long_q))
		else $error("duration or class set without a press item");

	a_long_lights_red: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && event_q && is_long_q && indication_q != '0) |-> red_q)
		else $error("long press did not light red lamp");

	a_short_lights_green: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && event_q && !is_long_q && indication_q != '0) |-> green_q)
		else $error("short press did not light green lamp");

endmodule
